// ===== rtl/spfc_pkg.sv =====
// ----------------------------------------------------------------------------
// Serial packet framer package
// Shared constants and types for the framer and its top level.
// ----------------------------------------------------------------------------
package spfc_pkg;

  localparam int unsigned PACKET_LENGTH_DEF = 34;
  localparam int unsigned POS_W             = 6;
  localparam int unsigned BYTE_W            = 8;

  localparam logic [BYTE_W-1:0] HDR_COMMAND  = 8'hAA;
  localparam logic [BYTE_W-1:0] HDR_PACKET   = 8'hAB;
  localparam logic [BYTE_W-1:0] CMD_MODE_ON  = 8'h22;
  localparam logic [BYTE_W-1:0] CMD_MODE_OFF = 8'h24;

  typedef enum logic [2:0] {
    EV_IGNORED  = 3'd0,
    EV_HEADER   = 3'd1,
    EV_DATA     = 3'd2,
    EV_MODE_ON  = 3'd3,
    EV_MODE_OFF = 3'd4,
    EV_UNKNOWN  = 3'd5,
    EV_READY    = 3'd6,
    EV_DROPPED  = 3'd7
  } event_code_t;

  typedef struct packed {
    event_code_t      event_code;
    logic             checksum_ok;
    logic             test_mode;
    logic [POS_W-1:0] byte_position;
  } spfc_result_t;

endpackage

// ===== rtl/spfc_framer.sv =====
// ----------------------------------------------------------------------------
// Framer core
// Frame tracking state, running checksum and test mode flag. Produces the
// result for the presented byte and updates its state when step_en is high.
// ----------------------------------------------------------------------------
module spfc_framer #(
  parameter int unsigned PACKET_LENGTH = spfc_pkg::PACKET_LENGTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step_en,
  input  logic [spfc_pkg::BYTE_W-1:0]      data_byte,
  output spfc_pkg::spfc_result_t           result
);
  import spfc_pkg::*;

  localparam logic [POS_W-1:0] SUM_END  = POS_W'(PACKET_LENGTH - 3);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_LENGTH - 1);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              cmd_frame_r, cmd_frame_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic              matched_r, matched_nxt;
  logic              mode_r, mode_nxt;
  event_code_t       ev;
  logic              ok;

  always_comb begin
    pos_nxt       = pos_r;
    cmd_frame_nxt = cmd_frame_r;
    sum_nxt       = sum_r;
    matched_nxt   = matched_r;
    mode_nxt      = mode_r;
    ev            = EV_IGNORED;
    ok            = 1'b0;
    if (pos_r == '0) begin
      if ((data_byte == HDR_PACKET) || (data_byte == HDR_COMMAND)) begin
        cmd_frame_nxt = (data_byte == HDR_COMMAND);
        sum_nxt       = data_byte;
        matched_nxt   = 1'b0;
        pos_nxt       = POS_W'(1);
        ev            = EV_HEADER;
      end
    end else if (cmd_frame_r) begin
      if (data_byte == CMD_MODE_ON) begin
        mode_nxt = 1'b1;
        ev       = EV_MODE_ON;
      end else if (data_byte == CMD_MODE_OFF) begin
        mode_nxt = 1'b0;
        ev       = EV_MODE_OFF;
      end else begin
        ev = EV_UNKNOWN;
      end
      cmd_frame_nxt = 1'b0;
      pos_nxt       = '0;
    end else begin
      if (pos_r < SUM_END) begin
        sum_nxt = sum_r + data_byte;
      end else if (pos_r == SUM_END) begin
        matched_nxt = (sum_r == data_byte);
      end
      if (pos_r >= LAST_POS) begin
        // The ready or dropped report uses the mode as it stands now.
        ev      = mode_r ? EV_READY : EV_DROPPED;
        ok      = matched_r;
        pos_nxt = '0;
      end else begin
        ev      = EV_DATA;
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  assign result.event_code    = ev;
  assign result.checksum_ok   = ok;
  assign result.test_mode     = mode_nxt;
  assign result.byte_position = pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      cmd_frame_r <= 1'b0;
      sum_r       <= '0;
      matched_r   <= 1'b0;
      mode_r      <= 1'b0;
    end else if (step_en) begin
      pos_r       <= pos_nxt;
      cmd_frame_r <= cmd_frame_nxt;
      sum_r       <= sum_nxt;
      matched_r   <= matched_nxt;
      mode_r      <= mode_nxt;
    end
  end

endmodule

// ===== rtl/serial_packet_framer_checksum.sv =====
// ----------------------------------------------------------------------------
// Serial packet framer with checksum
// Frames received serial bytes into command and packet frames and reports
// one result for every byte.
// ----------------------------------------------------------------------------
// A byte accepted into the input register moves into the result register
// as soon as that register is free, and its result then shows on out_valid
// (input register, then result register).
// Throughput: one byte per cycle while out_stall stays low, set by the state
// update of the framer core between the two registers.
// Reset (rst_n low, synchronous): both registers empty, framer idle, sum
// cleared, test mode off.
// ----------------------------------------------------------------------------
module serial_packet_framer_checksum #(
  parameter int unsigned PACKET_LENGTH = spfc_pkg::PACKET_LENGTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [spfc_pkg::BYTE_W-1:0]    in_data_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     out_event_code,
  output logic                           out_checksum_ok,
  output logic                           out_test_mode,
  output logic [spfc_pkg::POS_W-1:0]     out_byte_position
);
  import spfc_pkg::*;

  // Input register: holds one accepted byte until the result register can
  // take its result.
  logic              in_valid_r;
  logic [BYTE_W-1:0] in_byte_r;

  // Result register.
  logic              out_valid_r;
  spfc_result_t      out_res_r;

  spfc_result_t      step_res;
  logic              out_free;
  logic              step_en;
  logic              in_xfer;

  // The result register can load when it is empty or its result is being
  // transferred out in this cycle.
  assign out_free = !out_valid_r || !out_stall;

  // The framer state advances exactly once per byte, when the byte moves
  // from the input register into the result register.
  assign step_en  = in_valid_r && out_free;

  // The input register takes a new byte whenever it is empty or draining,
  // so bytes stream back to back while the result side keeps up.
  assign in_stall = in_valid_r && !out_free;
  assign in_xfer  = in_valid && !in_stall;

  spfc_framer #(
    .PACKET_LENGTH (PACKET_LENGTH)
  ) u_framer (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .data_byte (in_byte_r),
    .result    (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  // Payload needs no reset; it is only looked at while its valid is set.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_byte_r <= in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_code    = out_res_r.event_code;
  assign out_checksum_ok   = out_res_r.checksum_ok;
  assign out_test_mode     = out_res_r.test_mode;
  assign out_byte_position = out_res_r.byte_position;

endmodule

// ===== tb/tb_serial_packet_framer_checksum.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the serial packet framer with checksum
// Streams directed and random byte sequences (command frames, packets with
// good, bad and truncated checksums, and stray bytes) through the framer
// under random idling on both channels. Every byte is predicted here, and
// each result transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_serial_packet_framer_checksum;
  import spfc_pkg::*;

  // The block is built with its default packet length, so the predictor uses
  // the same value. The checksum byte sits three bytes before the end.
  localparam int PKT_LEN  = PACKET_LENGTH_DEF;
  localparam int SUM_END  = PKT_LEN - 3;
  localparam int PHASE_ITEMS = 533;
  localparam int MAX_SHOWN   = 10;

  logic                    clk           = 1'b0;
  logic                    rst_n         = 1'b0;
  logic                    in_valid      = 1'b0;
  logic                    in_stall;
  logic [BYTE_W-1:0]       in_data_byte  = '0;
  logic                    out_valid;
  logic                    out_stall     = 1'b0;
  logic [2:0]              out_event_code;
  logic                    out_checksum_ok;
  logic                    out_test_mode;
  logic [POS_W-1:0]        out_byte_position;

  // Bytes waiting to be sent, and the reports the framer owes us, oldest first.
  logic [BYTE_W-1:0]       byte_stream[$];
  spfc_result_t            expected_reports[$];

  // Percent of cycles in which the sender holds back or the receiver stalls.
  int unsigned             send_idle_pct = 0;
  int unsigned             recv_stall_pct = 0;
  int unsigned             fail_count    = 0;

  // Shadow of the framer state, advanced once per accepted byte.
  logic [POS_W-1:0]        frm_pos;
  logic                    in_cmd_frame;
  logic [BYTE_W-1:0]       pkt_sum;
  logic                    sum_hit;
  logic                    mode_on;

  serial_packet_framer_checksum u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_code    (out_event_code),
    .out_checksum_ok   (out_checksum_ok),
    .out_test_mode     (out_test_mode),
    .out_byte_position (out_byte_position)
  );

  always #5 clk = ~clk;

  // Advances the shadow framer by one byte and queues the report it causes.
  // The reported position is the one the byte takes, before the update; the
  // reported mode is the one after the byte has been applied.
  task automatic frame_byte(input logic [BYTE_W-1:0] b);
    spfc_result_t rep;
    rep.event_code    = EV_IGNORED;
    rep.checksum_ok   = 1'b0;
    rep.byte_position = frm_pos;
    if (frm_pos == '0) begin
      // Idle: only the two header bytes open a frame, anything else is dropped
      // without touching the state.
      if (b == HDR_PACKET || b == HDR_COMMAND) begin
        in_cmd_frame   = (b == HDR_COMMAND);
        pkt_sum        = b;
        sum_hit        = 1'b0;
        frm_pos        = POS_W'(1);
        rep.event_code = EV_HEADER;
      end
    end else if (in_cmd_frame) begin
      // Second byte of a command frame; an unknown code leaves the mode alone.
      if (b == CMD_MODE_ON) begin
        mode_on        = 1'b1;
        rep.event_code = EV_MODE_ON;
      end else if (b == CMD_MODE_OFF) begin
        mode_on        = 1'b0;
        rep.event_code = EV_MODE_OFF;
      end else begin
        rep.event_code = EV_UNKNOWN;
      end
      in_cmd_frame = 1'b0;
      frm_pos      = '0;
    end else begin
      // Packet body. Header values in here are plain data.
      if (frm_pos < SUM_END) begin
        pkt_sum = pkt_sum + b;
      end else if (frm_pos == SUM_END) begin
        sum_hit = (pkt_sum == b);
      end
      rep.event_code = EV_DATA;
      if (frm_pos + 1 >= PKT_LEN) begin
        rep.event_code  = mode_on ? EV_READY : EV_DROPPED;
        rep.checksum_ok = sum_hit;
        frm_pos         = '0;
      end else begin
        frm_pos = frm_pos + POS_W'(1);
      end
    end
    rep.test_mode = mode_on;
    expected_reports.push_back(rep);
  endtask

  // Compares one result transfer with the oldest outstanding report.
  task automatic check_report();
    spfc_result_t want;
    if (expected_reports.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_SHOWN) begin
        $display("%0t: unexpected result ev=%0d ok=%0d mode=%0d pos=%0d", $realtime,
                 out_event_code, out_checksum_ok, out_test_mode, out_byte_position);
      end
    end else begin
      want = expected_reports.pop_front();
      if (out_event_code !== want.event_code || out_checksum_ok !== want.checksum_ok ||
          out_test_mode !== want.test_mode || out_byte_position !== want.byte_position) begin
        fail_count++;
        if (fail_count <= MAX_SHOWN) begin
          $display("%0t: mismatch expected ev=%0d ok=%0d mode=%0d pos=%0d", $realtime,
                   want.event_code, want.checksum_ok, want.test_mode, want.byte_position);
          $display("%0t:          actual   ev=%0d ok=%0d mode=%0d pos=%0d", $realtime,
                   out_event_code, out_checksum_ok, out_test_mode, out_byte_position);
        end
      end
    end
  endtask

  // Payload bytes lean toward the interesting values now and then, so that
  // header and command codes show up inside packets and at the extremes.
  function automatic logic [BYTE_W-1:0] rand_payload();
    logic [BYTE_W-1:0] b;
    b = BYTE_W'($urandom_range(0, 255));
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 5))
        0:       b = HDR_COMMAND;
        1:       b = HDR_PACKET;
        2:       b = CMD_MODE_ON;
        3:       b = CMD_MODE_OFF;
        4:       b = '0;
        default: b = '1;
      endcase
    end
    return b;
  endfunction

  // Queues a packet frame. With a short keep count the packet is cut off, and
  // whatever follows is swallowed as packet data up to the packet length,
  // since the framer does not resynchronize on header bytes.
  task automatic queue_packet(input bit good_sum, input int keep);
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] b;
    sum = HDR_PACKET;
    byte_stream.push_back(HDR_PACKET);
    for (int i = 1; i < PKT_LEN && i < keep; i++) begin
      if (i < SUM_END) begin
        b   = rand_payload();
        sum = sum + b;
      end else if (i == SUM_END) begin
        b = good_sum ? sum : sum ^ BYTE_W'($urandom_range(1, 255));
      end else begin
        b = rand_payload();
      end
      byte_stream.push_back(b);
    end
  endtask

  // Sender. A byte stays on the bus, unchanged, until the framer takes it.
  // The next byte is presented in the same step in which the current one
  // transfers, so in_valid sees exactly one assignment per edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        frame_byte(in_data_byte);
      end
      if (!in_valid || !in_stall) begin
        if (byte_stream.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid     <= 1'b1;
          in_data_byte <= byte_stream.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Checks every result transfer and picks a fresh stall each cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_report();
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Stimulus and end of run. Queues are filled and watched on the falling
  // edge so that nothing here races the clocked sender and receiver.
  initial begin
    int made;
    int sz0;
    int pick;
    frm_pos      = '0;
    in_cmd_frame = 1'b0;
    pkt_sum      = '0;
    sum_hit      = 1'b0;
    mode_on      = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int ph = 0; ph < 3; ph++) begin
      // Sender light and receiver heavy, then the reverse, then full rate.
      case (ph)
        0: begin
          send_idle_pct  = 13;
          recv_stall_pct = 74;
        end
        1: begin
          send_idle_pct  = 74;
          recv_stall_pct = 13;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase

      if (ph == 0) begin
        // Stray bytes while idle at both extremes and a command code out of
        // frame, then every command: on twice, off twice, and unknown codes
        // including the extremes and both header values in the command slot.
        byte_stream.push_back(8'h00);
        byte_stream.push_back(8'hFF);
        byte_stream.push_back(CMD_MODE_ON);
        byte_stream.push_back(HDR_COMMAND);
        byte_stream.push_back(CMD_MODE_ON);
        byte_stream.push_back(HDR_COMMAND);
        byte_stream.push_back(CMD_MODE_ON);
        byte_stream.push_back(HDR_COMMAND);
        byte_stream.push_back(CMD_MODE_OFF);
        byte_stream.push_back(HDR_COMMAND);
        byte_stream.push_back(CMD_MODE_OFF);
        byte_stream.push_back(HDR_COMMAND);
        byte_stream.push_back(8'h00);
        byte_stream.push_back(HDR_COMMAND);
        byte_stream.push_back(8'hFF);
        byte_stream.push_back(HDR_COMMAND);
        byte_stream.push_back(HDR_PACKET);
        byte_stream.push_back(HDR_COMMAND);
        byte_stream.push_back(HDR_COMMAND);
        byte_stream.push_back(8'h23);
      end

      // Mostly well-formed frames with random content; stray bytes do not
      // count toward the phase size since the framer mostly ignores them.
      made = 0;
      while (made < PHASE_ITEMS) begin
        sz0  = byte_stream.size();
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          if ($urandom_range(0, 9) == 0) begin
            queue_packet(1'($urandom_range(0, 1)), $urandom_range(2, PKT_LEN - 1));
          end else begin
            queue_packet($urandom_range(0, 9) < 7, PKT_LEN);
          end
          made += byte_stream.size() - sz0;
        end else if (pick < 75) begin
          byte_stream.push_back(HDR_COMMAND);
          case ($urandom_range(0, 4))
            0, 1:    byte_stream.push_back(CMD_MODE_ON);
            2, 3:    byte_stream.push_back(CMD_MODE_OFF);
            default: byte_stream.push_back(rand_payload());
          endcase
          made += 2;
        end else begin
          repeat ($urandom_range(1, 3)) byte_stream.push_back(rand_payload());
        end
      end

      // Wait until the framer has answered every byte sent before the next phase.
      while (byte_stream.size() != 0 || in_valid || expected_reports.size() != 0) begin
        @(negedge clk);
      end
    end

    // Run on past the input and result registers, to catch strays.
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run of this stimulus.
  initial begin
    #(2_000_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/spfc_pkg.sv
rtl/spfc_framer.sv
rtl/serial_packet_framer_checksum.sv
tb/tb_serial_packet_framer_checksum.sv
